/* hdl/ccpe_pkg.sv */
`default_nettype none

package ccpe_pkg;

  // Field formats: coordinates are signed Q16.8, t is unsigned Q1.16 with 2^16 meaning one.
  localparam int unsigned COORD_W  = 24;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned PARAM_W  = FRAC_W + 1;
  localparam int unsigned TENS_W   = FRAC_W + 2;
  localparam int unsigned NUM_PTS  = 4;

  // Internal widths.
  localparam int unsigned TPROD_W  = 2 * PARAM_W;            // t-by-t products
  localparam int unsigned S_W      = TENS_W + 1;             // signed scale 2^F - tension
  localparam int unsigned WGT_W    = FRAC_W + 4;             // signed blending weight
  localparam int unsigned CARD_W   = S_W + WGT_W;            // scale times polynomial
  localparam int unsigned PROD_W   = WGT_W + COORD_W;        // weight times coordinate
  localparam int unsigned SUM_W    = PROD_W + 2;             // sum of four products
  localparam int unsigned RES_W    = SUM_W - FRAC_W;         // rounded sum before clamping

  localparam int unsigned STAGES   = 8;

  // Stream and configuration port widths.
  localparam int unsigned IN_RAW_W   = 2 * NUM_PTS * COORD_W + PARAM_W;
  localparam int unsigned IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = 2 * COORD_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = TENS_W;

  localparam int unsigned ONE_Q = 2 ** FRAC_W;

  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_KIND = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TENSION    = CFG_IDX_W'(1);

  localparam logic KIND_BEZIER   = 1'b0;
  localparam logic KIND_CARDINAL = 1'b1;

  localparam logic signed [RES_W-1:0] COORD_MAX_R = RES_W'((2 ** (COORD_W - 1)) - 1);
  localparam logic signed [RES_W-1:0] COORD_MIN_R = -RES_W'(2 ** (COORD_W - 1));
  localparam logic signed [COORD_W-1:0] COORD_MAX = COORD_W'((2 ** (COORD_W - 1)) - 1);
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  // Round half up by F bits of an unsigned t-domain product.
  function automatic logic [PARAM_W-1:0] rnd_t(input logic [TPROD_W-1:0] p);
    logic [TPROD_W-1:0] r;
    r = p + TPROD_W'(2 ** (FRAC_W - 1));
    return r[FRAC_W+PARAM_W-1:FRAC_W];
  endfunction

  // Round half up by F+1 bits of a signed scale product.
  function automatic logic signed [WGT_W-1:0] rnd_card(input logic signed [CARD_W-1:0] m);
    logic signed [CARD_W-1:0] r;
    r = m + CARD_W'(2 ** FRAC_W);
    return WGT_W'(r >>> (FRAC_W + 1));
  endfunction

endpackage

`default_nettype wire

/* hdl/cubic_curve_point_evaluator.sv */
`default_nettype none

// Evaluates one 2D point on a cubic Bezier or cardinal spline segment per beat. An input beat
// carries four signed Q16.8 control points and t in unsigned Q1.16 (values above one count as
// one); the result beat carries the point, clamped to the Q16.8 range, with tuser set when
// either coordinate was clamped. The datapath is an eight-stage pipeline (t powers, cubic
// terms, Bernstein weights and cardinal polynomials, tension scaling, weight selection, coordinate
// products, sum and rounding, clamping): a new beat is taken every cycle while the result side
// does not stall. Back-pressure on the result side stalls only the stages that hold data, so
// empty stages keep filling. Register 0 selects the curve kind
// (0 Bezier, 1 cardinal, reset cardinal) and register 1 holds the signed Q1.16 tension,
// clamped to [-1, 1]; write them only while no beat is in flight.
module cubic_curve_point_evaluator (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [ccpe_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire  [ccpe_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire                                s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, curve_param, zero fill
  input  wire  [ccpe_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  wire                                m_axis_tready_i,
  // point_x, point_y
  output logic [ccpe_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // saturated
  output logic                               m_axis_tuser_o
);

  localparam int unsigned CW = ccpe_pkg::COORD_W;
  localparam int unsigned PW = ccpe_pkg::PARAM_W;
  localparam int unsigned TW = ccpe_pkg::TPROD_W;
  localparam int unsigned WW = ccpe_pkg::WGT_W;
  localparam int unsigned NP = ccpe_pkg::NUM_PTS;
  localparam int unsigned NS = ccpe_pkg::STAGES;

  // Configuration.
  logic                                 kind_q;
  logic signed [ccpe_pkg::TENS_W-1:0]   tension_q;
  logic signed [ccpe_pkg::TENS_W-1:0]   tens_c;
  logic signed [ccpe_pkg::S_W-1:0]      s_val;

  // Handshake control.
  logic [NS:1] vld_q;
  logic [NS:1] vld_in;
  logic [NS:1] en;

  // Stage payloads.
  ccpe_pkg::point_t                     pts_in [NP];
  ccpe_pkg::point_t                     s1_pts_q [NP];
  ccpe_pkg::point_t                     s2_pts_q [NP];
  ccpe_pkg::point_t                     s3_pts_q [NP];
  ccpe_pkg::point_t                     s4_pts_q [NP];
  ccpe_pkg::point_t                     s5_pts_q [NP];

  logic [PW-1:0]                        t_raw, t_in, u_in;
  logic [PW-1:0]                        s1_t_q, s1_u_q;
  logic [TW-1:0]                        s1_tt_q, s1_uu_q;

  logic [PW-1:0]                        t2_d, u2_d;
  logic [PW-1:0]                        s2_t_q, s2_t2_q;
  logic [TW-1:0]                        s2_t3p_q, s2_u3p_q, s2_tu2p_q, s2_t2up_q;

  logic [PW-1:0]                        t3_d, u3_d;
  logic signed [WW-1:0]                 t_s, t2_s, t3_s;
  logic [PW-1:0]                        s3_bw_q [NP];
  logic signed [WW-1:0]                 s3_a0_q, s3_a1_q, s3_h1_q, s3_h2_q;

  logic [PW-1:0]                        s4_bw_q [NP];
  logic signed [WW-1:0]                 s4_h1_q, s4_h2_q;
  logic signed [ccpe_pkg::CARD_W-1:0]   s4_m0_q, s4_m1_q;

  logic signed [WW-1:0]                 w_d [NP];
  logic signed [WW-1:0]                 s5_w_q [NP];

  logic signed [ccpe_pkg::PROD_W-1:0]   s6_px_q [NP];
  logic signed [ccpe_pkg::PROD_W-1:0]   s6_py_q [NP];

  logic signed [ccpe_pkg::SUM_W-1:0]    sum_x, sum_y;
  logic signed [ccpe_pkg::RES_W-1:0]    s7_rx_q, s7_ry_q;

  logic signed [CW-1:0]                 out_x_d, out_y_d, out_x_q, out_y_q;
  logic                                 sat_x, sat_y, out_sat_q;

  // ---------------------------------------------------------------------------------------------
  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q    <= ccpe_pkg::KIND_CARDINAL;
      tension_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ccpe_pkg::CFG_CURVE_KIND: kind_q    <= cfg_data_i[0];
        ccpe_pkg::CFG_TENSION:    tension_q <= signed'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Scale s held in Q.(F+1): 2^F minus the clamped tension.
  always_comb begin
    if (tension_q > signed'(ccpe_pkg::TENS_W'(ccpe_pkg::ONE_Q))) begin
      tens_c = signed'(ccpe_pkg::TENS_W'(ccpe_pkg::ONE_Q));
    end else if (tension_q < -signed'(ccpe_pkg::TENS_W'(ccpe_pkg::ONE_Q))) begin
      tens_c = -signed'(ccpe_pkg::TENS_W'(ccpe_pkg::ONE_Q));
    end else begin
      tens_c = tension_q;
    end
    s_val = signed'(ccpe_pkg::S_W'(ccpe_pkg::ONE_Q)) - ccpe_pkg::S_W'(tens_c);
  end

  // ---------------------------------------------------------------------------------------------
  // Valid chain. A stage loads when it is empty or when the stage after it loads.
  always_comb begin
    en[NS] = !vld_q[NS] || m_axis_tready_i;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_in = {vld_q[NS-1:1], s_axis_tvalid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  assign s_axis_tready_o = en[1];
  assign m_axis_tvalid_o = vld_q[NS];

  // ---------------------------------------------------------------------------------------------
  // Stage 1: unpack, clamp t, square t and 1-t.
  always_comb begin
    for (int i = 0; i < NP; i++) begin
      pts_in[i].x = signed'(s_axis_tdata_i[2*i*CW +: CW]);
      pts_in[i].y = signed'(s_axis_tdata_i[(2*i+1)*CW +: CW]);
    end
    t_raw = s_axis_tdata_i[2*NP*CW +: PW];
    t_in  = (t_raw > PW'(ccpe_pkg::ONE_Q)) ? PW'(ccpe_pkg::ONE_Q) : t_raw;
    u_in  = PW'(ccpe_pkg::ONE_Q) - t_in;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_pts_q <= pts_in;
      s1_t_q   <= t_in;
      s1_u_q   <= u_in;
      s1_tt_q  <= TW'(t_in) * TW'(t_in);
      s1_uu_q  <= TW'(u_in) * TW'(u_in);
    end
  end

  // Stage 2: second powers, then the cubic and mixed products.
  assign t2_d = ccpe_pkg::rnd_t(s1_tt_q);
  assign u2_d = ccpe_pkg::rnd_t(s1_uu_q);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_pts_q  <= s1_pts_q;
      s2_t_q    <= s1_t_q;
      s2_t2_q   <= t2_d;
      s2_t3p_q  <= TW'(t2_d) * TW'(s1_t_q);
      s2_u3p_q  <= TW'(u2_d) * TW'(s1_u_q);
      s2_tu2p_q <= TW'(s1_t_q) * TW'(u2_d);
      s2_t2up_q <= TW'(t2_d) * TW'(s1_u_q);
    end
  end

  // Stage 3: Bernstein weights and the cardinal polynomials in t.
  assign t3_d = ccpe_pkg::rnd_t(s2_t3p_q);
  assign u3_d = ccpe_pkg::rnd_t(s2_u3p_q);
  assign t_s  = signed'(WW'(s2_t_q));
  assign t2_s = signed'(WW'(s2_t2_q));
  assign t3_s = signed'(WW'(t3_d));

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_pts_q   <= s2_pts_q;
      s3_bw_q[0] <= u3_d;
      s3_bw_q[1] <= ccpe_pkg::rnd_t(s2_tu2p_q + (s2_tu2p_q << 1));
      s3_bw_q[2] <= ccpe_pkg::rnd_t(s2_t2up_q + (s2_t2up_q << 1));
      s3_bw_q[3] <= t3_d;
      s3_a0_q    <= (t2_s <<< 1) - t3_s - t_s;
      s3_a1_q    <= t2_s - t3_s;
      s3_h1_q    <= (t3_s <<< 1) - (t2_s <<< 1) - t2_s + signed'(WW'(ccpe_pkg::ONE_Q));
      s3_h2_q    <= (t2_s <<< 1) + t2_s - (t3_s <<< 1);
    end
  end

  // Stage 4: tension scaling of the two independent cardinal polynomials.
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_pts_q <= s3_pts_q;
      s4_bw_q  <= s3_bw_q;
      s4_h1_q  <= s3_h1_q;
      s4_h2_q  <= s3_h2_q;
      s4_m0_q  <= ccpe_pkg::CARD_W'(s_val) * ccpe_pkg::CARD_W'(s3_a0_q);
      s4_m1_q  <= ccpe_pkg::CARD_W'(s_val) * ccpe_pkg::CARD_W'(s3_a1_q);
    end
  end

  // Stage 5: final weights. The outer cardinal terms are negatives of the inner ones before
  // rounding, so each is rounded on its own to keep round-half-up exact.
  always_comb begin
    if (kind_q == ccpe_pkg::KIND_BEZIER) begin
      for (int i = 0; i < NP; i++) begin
        w_d[i] = signed'(WW'(s4_bw_q[i]));
      end
    end else begin
      w_d[0] = ccpe_pkg::rnd_card(s4_m0_q);
      w_d[1] = ccpe_pkg::rnd_card(s4_m1_q) + s4_h1_q;
      w_d[2] = ccpe_pkg::rnd_card(-s4_m0_q) + s4_h2_q;
      w_d[3] = ccpe_pkg::rnd_card(-s4_m1_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_pts_q <= s4_pts_q;
      s5_w_q   <= w_d;
    end
  end

  // Stage 6: weight times coordinate, both lanes.
  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      for (int i = 0; i < NP; i++) begin
        s6_px_q[i] <= ccpe_pkg::PROD_W'(s5_w_q[i]) * ccpe_pkg::PROD_W'(s5_pts_q[i].x);
        s6_py_q[i] <= ccpe_pkg::PROD_W'(s5_w_q[i]) * ccpe_pkg::PROD_W'(s5_pts_q[i].y);
      end
    end
  end

  // Stage 7: exact sum, rounded half up to Q16.8.
  always_comb begin
    sum_x = ccpe_pkg::SUM_W'(2 ** (ccpe_pkg::FRAC_W - 1));
    sum_y = ccpe_pkg::SUM_W'(2 ** (ccpe_pkg::FRAC_W - 1));
    for (int i = 0; i < NP; i++) begin
      sum_x = sum_x + ccpe_pkg::SUM_W'(s6_px_q[i]);
      sum_y = sum_y + ccpe_pkg::SUM_W'(s6_py_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s7_rx_q <= ccpe_pkg::RES_W'(sum_x >>> ccpe_pkg::FRAC_W);
      s7_ry_q <= ccpe_pkg::RES_W'(sum_y >>> ccpe_pkg::FRAC_W);
    end
  end

  // Stage 8: clamp into the output register.
  always_comb begin
    sat_x   = 1'b1;
    sat_y   = 1'b1;
    out_x_d = s7_rx_q[CW-1:0];
    out_y_d = s7_ry_q[CW-1:0];
    priority if (s7_rx_q > ccpe_pkg::COORD_MAX_R) begin
      out_x_d = ccpe_pkg::COORD_MAX;
    end else if (s7_rx_q < ccpe_pkg::COORD_MIN_R) begin
      out_x_d = ccpe_pkg::COORD_MIN;
    end else begin
      sat_x = 1'b0;
    end
    priority if (s7_ry_q > ccpe_pkg::COORD_MAX_R) begin
      out_y_d = ccpe_pkg::COORD_MAX;
    end else if (s7_ry_q < ccpe_pkg::COORD_MIN_R) begin
      out_y_d = ccpe_pkg::COORD_MIN;
    end else begin
      sat_y = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      out_x_q   <= out_x_d;
      out_y_q   <= out_y_d;
      out_sat_q <= sat_x | sat_y;
    end
  end

  assign m_axis_tdata_o = {out_y_q, out_x_q};
  assign m_axis_tuser_o = out_sat_q;

  // ---------------------------------------------------------------------------------------------
  // Assertions.
  a_t_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> (s1_t_q <= PW'(ccpe_pkg::ONE_Q)))
    else $error("clamped t exceeds one");

  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      (out_x_q == ccpe_pkg::COORD_MAX || out_x_q == ccpe_pkg::COORD_MIN ||
       out_y_q == ccpe_pkg::COORD_MAX || out_y_q == ccpe_pkg::COORD_MIN))
    else $error("saturation flag without a clamped coordinate");

  a_room_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while the output stage is empty");

  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(vld_q[NS]) |-> $past(vld_q[NS-1]))
    else $error("result appeared without a beat in the previous stage");

endmodule

`default_nettype wire
